/* rtl/core/krct_pkg.sv */
// shared types and constants for the keyed remainder-carrying truncator
`default_nettype none
package krct_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 48;
	localparam int WHOLE_W = 32;
	localparam int AGE_W   = 8;
	localparam int ADDR_W  = 2;
	localparam int DATA_W  = 32;

	localparam logic KIND_CONVERT = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	localparam logic [ADDR_W-1:0] ADDR_AGE_LIMIT = 2'd0;

	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 8'd100;
	localparam logic [AGE_W-1:0] AGE_MAX         = 8'hFF;

	localparam logic [63:0] POS_SAT_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_SAT_LIMIT = 64'h0000_0000_8000_0000;
	localparam logic [WHOLE_W-1:0] WHOLE_MAX = 32'h7FFF_FFFF;
	localparam logic [WHOLE_W-1:0] WHOLE_MIN = 32'h8000_0000;

	typedef struct packed {
		logic load_in;
		logic match_en;
		logic calc_en;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/krct_in_if.sv */
// input channel: one convert or frame-tick transaction
`default_nettype none
interface krct_in_if
	import krct_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [KEY_W-1:0]          key;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink (input valid, input kind, input key, input value, output ready);
endinterface
`default_nettype wire

/* rtl/core/krct_out_if.sv */
// output channel: one converted integer transaction
`default_nettype none
interface krct_out_if
	import krct_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [WHOLE_W-1:0] whole_part;
	logic                      table_full;

	modport source (output valid, output whole_part, output table_full, input ready);
	modport sink (input valid, input whole_part, input table_full, output ready);
endinterface
`default_nettype wire

/* rtl/core/krct_ctrl.sv */
// controller state machine: accept, table match, arithmetic and write back
`default_nettype none
module krct_ctrl
	import krct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_CALC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_out;
	logic   accept;

	assign can_out   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) || ((state_q == S_CALC) && can_out);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign cmd.load_in  = accept;
	assign cmd.match_en = (state_q == S_MATCH);
	assign cmd.calc_en  = (state_q == S_CALC) && can_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.calc_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					// a frame tick is finished by the aging pass
					state_q <= status.is_tick ? S_IDLE : S_CALC;
				end
				S_CALC: begin
					if (can_out) begin
						state_q <= accept ? S_MATCH : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/krct_dp.sv */
// datapath: key table, remainder memory, aging and truncation arithmetic
`default_nettype none
module krct_dp
	import krct_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ctrl_cmd_t                 cmd,
	output dp_status_t                     status,
	input  wire logic [AGE_W-1:0]          age_limit,
	input  wire logic                      in_kind,
	input  wire logic [KEY_W-1:0]          in_key,
	input  wire logic [VALUE_W-1:0]        in_value,
	output logic [WHOLE_W-1:0]             whole_part,
	output logic                           table_full
);

	localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int REM_W = FRACTION_BITS + 1;
	localparam int SUM_W = VALUE_W + 1;

	// captured transaction
	logic               kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	// table
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]         key_tab_q [TABLE_ENTRIES];
	logic [AGE_W-1:0]         age_q     [TABLE_ENTRIES];
	logic [REM_W-1:0]         rem_mem   [TABLE_ENTRIES];

	// match results
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic                     hit_any;
	logic                     free_any;
	logic [IW-1:0]            hit_idx;
	logic [IW-1:0]            free_idx;
	logic                     alloc;
	logic                     conv_match;
	logic                     tick_en;

	logic               hit_s1;
	logic               full_s1;
	logic [IW-1:0]      slot_s1;
	logic [REM_W-1:0]   rem_rd_s1;

	// arithmetic
	logic [REM_W-1:0]   rem_use;
	logic [SUM_W-1:0]   sum;
	logic               neg;
	logic [SUM_W-1:0]   mag;
	logic [63:0]        ip64;
	logic [REM_W-1:0]   fp_ext;
	logic [REM_W-1:0]   new_rem;
	logic [WHOLE_W-1:0] whole;
	logic               rem_wr;

	logic [WHOLE_W-1:0] whole_q;
	logic               full_q;

	assign status.is_tick = (kind_q == KIND_TICK);
	assign conv_match     = cmd.match_en && (kind_q == KIND_CONVERT);
	assign tick_en        = cmd.match_en && (kind_q == KIND_TICK);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q  <= in_kind;
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && (key_tab_q[i] == key_q);
		end
	end

	// lowest-numbered hit and lowest-numbered free entry
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign alloc = conv_match && !hit_any && free_any;

	always_ff @(posedge clk) begin
		if (conv_match) begin
			hit_s1    <= hit_any;
			full_s1   <= !hit_any && !free_any;
			slot_s1   <= hit_any ? hit_idx : free_idx;
			rem_rd_s1 <= rem_mem[hit_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			key_tab_q[free_idx] <= key_q;
		end
	end

	assign rem_wr = cmd.calc_en && !full_s1;

	always_ff @(posedge clk) begin
		if (rem_wr) begin
			rem_mem[slot_s1] <= new_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (tick_en && valid_q[i]) begin
					// aging saturates; entry drops once it reaches the limit
					if (age_q[i] != AGE_MAX) begin
						if ((age_q[i] + AGE_W'(1)) >= age_limit) begin
							valid_q[i] <= 1'b0;
						end
					end else if (AGE_MAX >= age_limit) begin
						valid_q[i] <= 1'b0;
					end
				end else if (alloc && (free_idx == IW'(i))) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tick_en && valid_q[i]) begin
				if (age_q[i] != AGE_MAX) begin
					age_q[i] <= age_q[i] + AGE_W'(1);
				end
			end else if (rem_wr && (slot_s1 == IW'(i))) begin
				age_q[i] <= '0;
			end
		end
	end

	// sum, truncate toward zero, split into integer and signed fraction
	assign rem_use = hit_s1 ? rem_rd_s1 : '0;
	assign sum     = {value_q[VALUE_W-1], value_q}
	               + {{(SUM_W-REM_W){rem_use[REM_W-1]}}, rem_use};
	assign neg     = sum[SUM_W-1];
	assign mag     = neg ? (SUM_W'(0) - sum) : sum;
	assign ip64    = 64'(mag[SUM_W-1:FRACTION_BITS]);
	assign fp_ext  = {1'b0, mag[FRACTION_BITS-1:0]};
	assign new_rem = neg ? (REM_W'(0) - fp_ext) : fp_ext;

	always_comb begin
		if (neg) begin
			whole = (ip64 > NEG_SAT_LIMIT) ? WHOLE_MIN : (WHOLE_W'(0) - ip64[WHOLE_W-1:0]);
		end else begin
			whole = (ip64 > POS_SAT_LIMIT) ? WHOLE_MAX : ip64[WHOLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_en) begin
			whole_q <= whole;
			full_q  <= full_s1;
		end
	end

	assign whole_part = whole_q;
	assign table_full = full_q;

endmodule
`default_nettype wire

/* rtl/core/keyed_remainder_carrying_truncator.sv */
// a convert result is registered once its transaction has passed the table match and
// arithmetic states, which waits while the output is stalled; the next input is taken in
// that state while the arithmetic and table write back of the previous one complete
// a frame tick passes only the table match state and ages all entries in one pass, no result
// reset clears the entry valid bits and sets age_limit to 100; no clearing pass
`default_nettype none
module keyed_remainder_carrying_truncator
	import krct_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	krct_in_if.sink                in_ch,
	krct_out_if.source             out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	ctrl_cmd_t        cmd;
	dp_status_t       status;
	logic [AGE_W-1:0] age_limit_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_AGE_LIMIT);
	assign prdata = (paddr == ADDR_AGE_LIMIT) ? DATA_W'(age_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RESET;
		end else if (cfg_wr) begin
			age_limit_q <= pwdata[AGE_W-1:0];
		end
	end

	krct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	krct_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.age_limit  (age_limit_q),
		.in_kind    (in_ch.kind),
		.in_key     (in_ch.key),
		.in_value   (in_ch.value),
		.whole_part (out_ch.whole_part),
		.table_full (out_ch.table_full)
	);

endmodule
`default_nettype wire

/* rtl/core/krct_chk.sv */
// port-level checker for the truncator and its bind to the top level
`default_nettype none
module krct_chk
	import krct_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [31:0]       whole_part,
	input wire logic              table_full,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [31:0]       pwdata,
	input wire logic [31:0]       prdata
);

	// a stalled result transaction keeps its valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// a stalled result transaction keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(whole_part) && $stable(table_full))
		else $error("result payload changed while stalled");

	// the table match cycle after an accept takes no new transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted during table match");

	// a new result is always preceded by a match cycle with input closed
	a_result_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready, 2))
		else $error("result appeared without a match cycle");

	// age_limit reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr == ADDR_AGE_LIMIT)
		|=> (paddr != ADDR_AGE_LIMIT) || (prdata[7:0] == $past(pwdata[7:0])))
		else $error("age_limit readback mismatch");

endmodule

bind keyed_remainder_carrying_truncator krct_chk u_krct_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.whole_part (out_ch.whole_part),
	.table_full (out_ch.table_full),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);
`default_nettype wire
